// ----- design/fqp_pkg.sv -----
`default_nettype none
package fqp_pkg;

   typedef enum logic [1:0] {
      FMT_HALF = 2'd0,
      FMT_E8   = 2'd1,
      FMT_E2M1 = 2'd2,
      FMT_SIGN = 2'd3
   } format_type;

   localparam logic [30:0] INF_ABS      = 31'h7F800000;
   localparam logic [30:0] TH_LARGE     = 31'h3BF80000;
   localparam logic [30:0] TH_ROUND     = 31'h3BF00000;
   localparam logic [9:0]  E8_OFFSET    = 10'd104;
   localparam logic [30:0] E2M1_UP_1P0  = 31'h3F3FFFF8;
   localparam logic [30:0] E2M1_MID_1P25 = 31'h3FA00000;
   localparam logic [30:0] E2M1_UP_2P0  = 31'h3FDFFFFC;
   localparam logic [30:0] E2M1_MID_2P5 = 31'h40200000;
   localparam logic [30:0] E2M1_UP_4P0  = 31'h405FFFFE;
   localparam logic [30:0] E2M1_MID_5P0 = 31'h40A00000;

   function automatic logic [15:0] to_half(input logic [31:0] x);
      logic [7:0]  ex;
      logic [22:0] fr;
      logic [3:0]  k;
      logic [15:0] r;
      ex = x[30:23];
      fr = x[22:0];
      k  = 4'(8'd113 - ex);
      r  = 16'h0000;
      if (ex == 8'hFF) begin
         r = {1'b0, 5'h1F, 9'd0, (fr != 23'd0)};
      end else if (ex == 8'd0 || ex < 8'd103) begin
         r = 16'h0000;
      end else if (ex < 8'd113) begin
         r = (16'd1024 >> k) + 16'(fr >> (5'd13 + 5'(k)));
      end else if (ex > 8'd142) begin
         r = {1'b0, 5'h1F, 10'd0};
      end else begin
         r = {1'b0, 5'(ex - 8'd112), fr[22:13]};
      end
      return {x[31], r[14:0]};
   endfunction

   function automatic logic [7:0] to_e8(input logic [31:0] x);
      logic [30:0] a;
      logic        not_nan, large_e, r111, odd;
      logic [31:0] rounded;
      logic [2:0]  m;
      logic [9:0]  ep;
      logic [7:0]  esfp, r;
      a       = x[30:0];
      not_nan = a <= INF_ABS;
      large_e = not_nan && a >= TH_LARGE;
      r111    = not_nan && a >= TH_ROUND;
      odd     = large_e ? a[20] : a[21];
      rounded = {1'b0, a} + 32'(odd) + (large_e ? 32'h0007FFFF : 32'h000FFFFF);
      m       = r111 ? rounded[22:20] : {1'b0, rounded[22:21]};
      ep      = {1'b0, rounded[31:23]} - E8_OFFSET;
      if (ep == 10'd0 && m == 3'd0) begin
         m = 3'd1;
      end
      esfp = ep[7:0] - (r111 ? 8'd8 : 8'd0);
      r    = ((r111 ? (esfp << 3) : (esfp << 2)) | {5'd0, m} | {x[31], 7'd0});
      if (ep[9]) begin
         r = 8'd0;
      end
      return r;
   endfunction

   function automatic logic [3:0] to_e2m1(input logic [31:0] x);
      logic [30:0] a;
      logic [2:0]  c;
      a = x[30:0];
      c = 3'd1 + 3'(a >= E2M1_UP_1P0) + 3'(a > E2M1_MID_1P25) + 3'(a >= E2M1_UP_2P0)
          + 3'(a > E2M1_MID_2P5) + 3'(a >= E2M1_UP_4P0) + 3'(a > E2M1_MID_5P0);
      if (a >= INF_ABS) begin
         return 4'h7;
      end else if (a == 31'd0) begin
         return 4'h0;
      end
      return {x[31], c};
   endfunction

   function automatic logic to_sign(input logic [31:0] x);
      if (x[30:0] > INF_ABS) begin
         return 1'b0;
      end
      return !x[31] || x[30:0] == 31'd0;
   endfunction

endpackage
`default_nettype wire

// ----- design/float_quantize_pack_top.sv -----
`default_nettype none
// Streaming float32 quantizer: half, 8-bit float, packed e2m1 nibbles or packed
// sign bits, picked by the format register (write it only while idle; a write
// clears the partial byte). Each beat passes an input register and one
// conversion stage into a result register, so one beat is taken per cycle
// while the output is not stalled; packed formats emit a beat only
// when the byte fills or end_of_vector flushes it.
module float_quantize_pack_top
   import fqp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_sample_bits,
   input  wire logic        req_end_of_vector,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_code_word,
   output logic             rsp_final_word,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_format
);

   format_type  format_ff, format_in;
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_bits_ff;
   logic        s1_eov_ff;
   logic        out_ready, cfg_write;
   logic [15:0] half_word;
   logic [7:0]  e8_code;
   logic [3:0]  e2m1_nib;
   logic        sign_bit;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;
   assign req_stall = s1_valid_ff && !out_ready;

   always_comb begin
      format_in   = cfg_write ? format_type'(csr_format) : format_ff;
      s1_valid_in = req_stall ? s1_valid_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff   <= FMT_HALF;
         s1_valid_ff <= 1'b0;
      end else begin
         format_ff   <= format_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_bits_ff <= req_sample_bits;
         s1_eov_ff  <= req_end_of_vector;
      end
   end

   fqp_convert u_convert (
      .sample_bits (s1_bits_ff),
      .half_word   (half_word),
      .e8_code     (e8_code),
      .e2m1_nib    (e2m1_nib),
      .sign_bit    (sign_bit)
   );

   fqp_pack u_pack (
      .clock          (clock),
      .reset          (reset),
      .fmt            (format_ff),
      .cfg_clear      (cfg_write),
      .in_valid       (s1_valid_ff),
      .in_ready       (out_ready),
      .half_word      (half_word),
      .e8_code        (e8_code),
      .e2m1_nib       (e2m1_nib),
      .sign_bit       (sign_bit),
      .eov            (s1_eov_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_word  (rsp_code_word),
      .rsp_final_word (rsp_final_word)
   );

endmodule
`default_nettype wire

// ----- design/fqp_convert.sv -----
`default_nettype none
module fqp_convert
   import fqp_pkg::*;
(
   input  wire logic [31:0] sample_bits,
   output logic      [15:0] half_word,
   output logic      [7:0]  e8_code,
   output logic      [3:0]  e2m1_nib,
   output logic             sign_bit
);

   always_comb begin
      half_word = to_half(sample_bits);
      e8_code   = to_e8(sample_bits);
      e2m1_nib  = to_e2m1(sample_bits);
      sign_bit  = to_sign(sample_bits);
   end

endmodule
`default_nettype wire

// ----- design/fqp_pack.sv -----
`default_nettype none
module fqp_pack
   import fqp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire format_type  fmt,
   input  wire logic        cfg_clear,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [15:0] half_word,
   input  wire logic [7:0]  e8_code,
   input  wire logic [3:0]  e2m1_nib,
   input  wire logic        sign_bit,
   input  wire logic        eov,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_code_word,
   output logic             rsp_final_word
);

   logic [7:0]  pack_byte_ff, pack_byte_in, byte_next;
   logic [2:0]  pack_count_ff, pack_count_in, count_next;
   logic        rsp_valid_ff, rsp_valid_in, emit, take;
   logic [15:0] word_ff, word_in;
   logic        final_ff, final_in;

   assign in_ready = !rsp_valid_ff || !rsp_stall;
   assign take     = in_valid && in_ready;

   always_comb begin
      byte_next  = pack_byte_ff;
      count_next = pack_count_ff;
      emit       = 1'b1;
      word_in    = 16'd0;
      case (fmt)
         FMT_HALF: word_in = half_word;
         FMT_E8:   word_in = {8'd0, e8_code};
         FMT_E2M1: begin
            if (pack_count_ff == 3'd0) begin
               byte_next  = {4'd0, e2m1_nib};
               count_next = 3'd1;
               emit       = eov;
            end else begin
               byte_next = {e2m1_nib, pack_byte_ff[3:0]};
            end
            word_in = {8'd0, byte_next};
         end
         default: begin
            byte_next  = pack_byte_ff | (8'(sign_bit) << pack_count_ff);
            count_next = pack_count_ff + 3'd1;
            emit       = (count_next == 3'd0) || eov;
            word_in    = {8'd0, byte_next};
         end
      endcase
      if (fmt == FMT_HALF || fmt == FMT_E8) begin
         byte_next  = pack_byte_ff;
         count_next = pack_count_ff;
      end else if (emit) begin
         byte_next  = 8'd0;
         count_next = 3'd0;
      end
   end

   always_comb begin
      pack_byte_in  = pack_byte_ff;
      pack_count_in = pack_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      final_in      = eov;
      if (cfg_clear) begin
         pack_byte_in  = 8'd0;
         pack_count_in = 3'd0;
      end else if (take) begin
         pack_byte_in  = byte_next;
         pack_count_in = count_next;
      end
      if (take) begin
         rsp_valid_in = emit;
      end else if (in_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_byte_ff  <= 8'd0;
         pack_count_ff <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pack_byte_ff  <= pack_byte_in;
         pack_count_ff <= pack_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff  <= word_in;
         final_ff <= final_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_word  = word_ff;
   assign rsp_final_word = final_ff;

`ifndef SYNTHESIS
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (fmt == FMT_HALF || fmt == FMT_E8) |-> pack_count_ff == 3'd0)
      else $error("pack count nonzero in unpacked format");
   a_nib_count: assert property (@(posedge clock) disable iff (reset)
      (fmt == FMT_E2M1) |-> pack_count_ff <= 3'd1)
      else $error("nibble count out of range");
   a_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && fmt != FMT_HALF) |-> word_ff[15:8] == 8'd0)
      else $error("upper byte set in byte format");
`endif

endmodule
`default_nettype wire
